// ===== rtl/wpst_pkg.sv =====
package wpst_pkg;

    localparam int ENTRIES   = 256;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int FRAC_BITS = 16;
    localparam int DEV_W     = 32;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 9;
    localparam int TREE_W    = SUM_W + CNT_W;

    localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

    // shared divider: quotient width and divisor width
    localparam int DIV_NW = 58;
    localparam int DIV_DW = 42;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_AVAIL = 2'd1;
    localparam logic [1:0] KIND_PICK  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/wpst_ram.sv =====
module wpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wpst_div.sv =====
module wpst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wpst_pkg::t_div_req i_req,
    output wpst_pkg::t_div_rsp o_rsp
);

    // restoring divider, one quotient bit per cycle
    logic [wpst_pkg::DIV_NW-1:0] r_num;
    logic [wpst_pkg::DIV_DW-1:0] r_den;
    logic [wpst_pkg::DIV_DW-1:0] r_rem;
    logic [5:0]                  r_cnt;
    logic                        r_done;
    logic [wpst_pkg::DIV_DW:0]   trial;
    logic                        qbit;

    always_comb begin
        trial = {r_rem, r_num[wpst_pkg::DIV_NW-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_req.start) begin
                r_num <= i_req.num;
                r_den <= i_req.den;
                r_rem <= '0;
                r_cnt <= 6'(wpst_pkg::DIV_NW);
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
                r_num <= {r_num[wpst_pkg::DIV_NW-2:0], qbit};
                if (qbit) begin
                    r_rem <= wpst_pkg::DIV_DW'(trial - {1'b0, r_den});
                end else begin
                    r_rem <= trial[wpst_pkg::DIV_DW-1:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

endmodule

// ===== rtl/weighted_pick_sum_tree.sv =====
// Channel   Dir   Handshake               Payload
// s_*       in    s_tvalid / s_tready     s_tdata: index, deviation, flag, random; s_tuser: kind
// m_*       out   m_tvalid / m_tready     m_tdata: index, total, count; m_tuser: picked
// cfg       in    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Load/availability item: an ancestor walk of up to 8 levels, with a tree write at each
// node entered from the left. Pick: a descent of up to 9 levels, each through S_PK_RD,
// S_PK_MUL and S_PK_CMP on the tree RAM port, plus the shared divider and an ancestor walk
// when sharing. Renormalization adds one divide per entry, then a tree clear and a rebuild
// that walks the ancestors of every available entry.
// Reset: synchronous; a clearing pass zeroes every entry of both RAMs before s_tready rises.
// Stalls: one item at a time; a held result blocks only the final hand-off stage.
module weighted_pick_sum_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [7:0] entry_index, [39:8] deviation_value,
                                     // [40] available_flag, [56:41] random_fraction
    input  logic [1:0]  s_tuser,     // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [7:0] picked_index, [47:8] total_weight,
                                     // [56:48] counted_entries
    output logic [0:0]  m_tuser,     // [0] picked
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NS = 27;

    typedef enum logic [NS-1:0] {
        S_CLEAR   = NS'(1) << 0,
        S_IDLE    = NS'(1) << 1,
        S_UPD_RD  = NS'(1) << 2,
        S_UPD     = NS'(1) << 3,
        S_PW_TEST = NS'(1) << 4,
        S_PW_WR   = NS'(1) << 5,
        S_PK_M1   = NS'(1) << 6,
        S_PK_M2   = NS'(1) << 7,
        S_PK_M3   = NS'(1) << 8,
        S_PK_M4   = NS'(1) << 9,
        S_PK_RD   = NS'(1) << 10,
        S_PK_MUL  = NS'(1) << 11,
        S_PK_CMP  = NS'(1) << 12,
        S_SH_MUL  = NS'(1) << 13,
        S_SH_DIV  = NS'(1) << 14,
        S_SH_WAIT = NS'(1) << 15,
        S_RN_M    = NS'(1) << 16,
        S_RN_T    = NS'(1) << 17,
        S_RN_RD   = NS'(1) << 18,
        S_RN_MUL  = NS'(1) << 19,
        S_RN_DIV  = NS'(1) << 20,
        S_RN_WAIT = NS'(1) << 21,
        S_RB_CLR  = NS'(1) << 22,
        S_RB_NEXT = NS'(1) << 23,
        S_RB_DEV  = NS'(1) << 24,
        S_FIN_M   = NS'(1) << 25,
        S_FIN     = NS'(1) << 26
    } t_state;

    // where the ancestor walk returns to
    typedef enum logic [1:0] {
        RET_FIN,
        RET_SHARE,
        RET_REBUILD
    } t_ret;

    t_state r_state;
    t_ret   r_ret;

    // architectural state
    logic [wpst_pkg::ENTRIES-1:0] r_avail;
    logic [31:0]                  r_base;
    logic signed [39:0]           r_dtot;
    logic [8:0]                   r_ctot;
    logic [15:0]                  r_share;
    logic [8:0]                   r_entry_count;

    // item and working registers
    logic [1:0]          r_kind;
    logic [7:0]          r_idx;
    logic signed [31:0]  r_dv;
    logic                r_flag;
    logic [15:0]         r_rnd;
    logic [8:0]          r_i;
    logic [8:0]          r_p;
    logic signed [39:0]  r_ddev;
    logic signed [1:0]   r_dcnt;
    logic [56:0]         r_prod;
    logic [39:0]         r_tot;
    logic signed [47:0]  r_w;
    logic [9:0]          r_j;
    logic signed [39:0]  r_lsum;
    logic signed [31:0]  r_devk;
    logic                r_got;
    logic [7:0]          r_winner;
    logic                r_neg;
    logic [32:0]         r_shmag;
    logic [41:0]         r_t;

    // result register
    logic        r_m_valid;
    logic [7:0]  r_m_idx;
    logic        r_m_got;
    logic [39:0] r_m_tot;
    logic [8:0]  r_m_cnt;

    // RAM ports
    logic                       dev_we, tree_we;
    logic [7:0]                 dev_addr, tree_addr;
    logic [31:0]                dev_wdata, dev_rdata;
    logic [wpst_pkg::TREE_W-1:0] tree_wdata, tree_rdata;

    wpst_pkg::t_div_req div_req;
    wpst_pkg::t_div_rsp div_rsp;

    // shared multiplier
    logic [40:0] mul_a;
    logic [15:0] mul_b;

    // datapath
    logic [8:0]         cnt_eff, div_small;
    logic [31:0]        renorm_lim;
    logic signed [47:0] base_s, dtot_s, prod_s, tot_s;
    logic signed [31:0] dev_rd_s;
    logic signed [39:0] tree_lsum;
    logic [8:0]         tree_lcnt;
    logic [7:0]         pk_k, pw_addr;
    logic signed [47:0] left_s, own_s, fit_s;
    logic [9:0]         j2, j2p1;
    logic signed [47:0] wk, wk_mag, sh_s, per_s, nb_s, nd_pre;
    logic [31:0]        nb;
    logic signed [31:0] nd_sh, nd_rn;
    logic signed [47:0] wi, wi_mag, q_s, v_s;
    logic [40:0]        rn_q;
    logic signed [39:0] old_c, new_c;
    logic signed [1:0]  upd_dcnt;

    function automatic logic signed [31:0] f_clamp_s32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    function automatic logic [39:0] f_clamp_tot(input logic signed [47:0] v);
        logic [39:0] res;
        if (v < 48'sd0) begin
            res = '0;
        end else if (v > 48'sh00FF_FFFF_FFFF) begin
            res = '1;
        end else begin
            res = v[39:0];
        end
        return res;
    endfunction

    wpst_ram #(.WIDTH(32), .DEPTH(wpst_pkg::ENTRIES)) u_dev_ram (
        .i_clk   (i_clk),
        .i_we    (dev_we),
        .i_addr  (dev_addr),
        .i_wdata (dev_wdata),
        .o_rdata (dev_rdata)
    );

    // per node: {left deviation sum, left count}
    wpst_ram #(.WIDTH(wpst_pkg::TREE_W), .DEPTH(wpst_pkg::ENTRIES)) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_addr  (tree_addr),
        .i_wdata (tree_wdata),
        .o_rdata (tree_rdata)
    );

    wpst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        cnt_eff    = (r_entry_count == 9'd0) ? 9'd1 : r_entry_count;
        div_small  = (cnt_eff > 9'd1) ? cnt_eff - 9'd1 : 9'd1;
        renorm_lim = 32'(cnt_eff) << wpst_pkg::FRAC_BITS;
        base_s     = $signed({16'b0, r_base});
        dtot_s     = 48'(r_dtot);
        prod_s     = $signed({7'b0, r_prod[40:0]});
        tot_s      = dtot_s + prod_s;
        dev_rd_s   = $signed(dev_rdata);
        tree_lsum  = $signed(tree_rdata[wpst_pkg::TREE_W-1:wpst_pkg::CNT_W]);
        tree_lcnt  = tree_rdata[wpst_pkg::CNT_W-1:0];
        pw_addr    = r_p[8:1] - 8'd1;

        // descent
        pk_k   = 8'(r_j - 10'd1);
        left_s = 48'(r_lsum) + prod_s;
        own_s  = r_avail[pk_k] ? 48'(r_devk) + base_s : 48'sd0;
        fit_s  = left_s + own_s;
        j2     = {r_j[8:0], 1'b0};
        j2p1   = {r_j[8:0], 1'b1};

        // weight sharing, signs applied to magnitudes
        wk     = 48'(r_devk) + base_s;
        wk_mag = (wk < 48'sd0) ? -wk : wk;
        sh_s   = $signed({15'b0, r_shmag});
        per_s  = $signed({15'b0, div_rsp.quo[32:0]});
        if (r_neg) begin
            sh_s  = -sh_s;
            per_s = -per_s;
        end
        nb_s = base_s + per_s;
        if (nb_s < 48'sd0) begin
            nb = '0;
        end else if (nb_s > 48'sh0000_FFFF_FFFF) begin
            nb = '1;
        end else begin
            nb = nb_s[31:0];
        end
        nd_pre = 48'(r_devk) - sh_s - per_s;
        nd_sh  = f_clamp_s32(nd_pre);

        // renormalization
        wi     = 48'(dev_rd_s) + base_s;
        wi_mag = (wi < 48'sd0) ? -wi : wi;
        rn_q   = (div_rsp.quo > 58'(41'h100_0000_0000)) ? 41'h100_0000_0000
                                                        : div_rsp.quo[40:0];
        q_s    = $signed({7'b0, rn_q});
        v_s    = r_neg ? -q_s : q_s;
        nd_rn  = f_clamp_s32(v_s - $signed({16'b0, wpst_pkg::ONE_Q}));

        // load / availability contribution change
        old_c    = r_avail[r_idx] ? 40'(dev_rd_s) : 40'sd0;
        new_c    = r_flag ? ((r_kind == wpst_pkg::KIND_LOAD) ? 40'(r_dv) : 40'(dev_rd_s))
                          : 40'sd0;
        upd_dcnt = $signed({1'b0, r_flag}) - $signed({1'b0, r_avail[r_idx]});
    end

    // RAM and multiplier steering
    always_comb begin
        dev_we     = 1'b0;
        dev_addr   = r_i[7:0];
        dev_wdata  = '0;
        tree_we    = 1'b0;
        tree_addr  = pw_addr;
        tree_wdata = '0;
        mul_a      = 41'(r_base);
        mul_b      = 16'(r_ctot);
        unique case (r_state)
            S_CLEAR: begin
                dev_we    = 1'b1;
                tree_we   = 1'b1;
                tree_addr = r_i[7:0];
            end
            S_UPD_RD: dev_addr = r_idx;
            S_UPD: begin
                dev_addr  = r_idx;
                dev_we    = (r_kind == wpst_pkg::KIND_LOAD);
                dev_wdata = r_dv;
            end
            S_PW_WR: begin
                tree_we    = 1'b1;
                tree_wdata = {tree_lsum + r_ddev, tree_lcnt + 9'(r_dcnt)};
            end
            S_PK_M3: begin
                mul_a = 41'(r_tot);
                mul_b = r_rnd;
            end
            S_PK_RD: begin
                dev_addr  = pk_k;
                tree_addr = pk_k;
            end
            S_PK_MUL: mul_b = 16'(tree_lcnt);
            S_SH_MUL: begin
                mul_a = wk_mag[40:0];
                mul_b = r_share;
            end
            S_SH_WAIT: begin
                dev_addr  = r_winner;
                dev_we    = div_rsp.done;
                dev_wdata = nd_sh;
            end
            S_RN_M: mul_b = 16'(cnt_eff);
            S_RN_MUL: begin
                mul_a = wi_mag[40:0];
                mul_b = 16'(cnt_eff);
            end
            S_RN_WAIT: begin
                dev_we    = div_rsp.done;
                dev_wdata = nd_rn;
            end
            S_RB_CLR: begin
                tree_we   = 1'b1;
                tree_addr = r_i[7:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start = (r_state == S_SH_DIV) || (r_state == S_RN_DIV);
        if (r_state == S_SH_DIV) begin
            div_req.num = {25'b0, r_prod[48:16]};
            div_req.den = 42'(div_small);
        end else begin
            div_req.num = {r_prod[41:0], 16'b0};
            div_req.den = r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_i           <= '0;
            r_avail       <= '0;
            r_base        <= wpst_pkg::ONE_Q;
            r_dtot        <= '0;
            r_ctot        <= '0;
            r_share       <= '0;
            r_entry_count <= 9'd256;
            r_m_valid     <= 1'b0;
        end else begin
            r_prod <= 57'(mul_a) * 57'(mul_b);

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    1'b0: r_share       <= i_cfg_data;
                    1'b1: r_entry_count <= i_cfg_data[8:0];
                    default: ;
                endcase
            end

            if ((r_state == S_FIN) && (!r_m_valid || m_tready)) begin
                r_m_valid <= 1'b1;
                r_m_idx   <= r_winner;
                r_m_got   <= r_got;
                r_m_tot   <= f_clamp_tot(tot_s);
                r_m_cnt   <= r_ctot;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_i <= r_i + 9'd1;
                    if (r_i == 9'(wpst_pkg::ENTRIES - 1)) begin
                        r_i     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_kind   <= s_tuser;
                        r_idx    <= s_tdata[7:0];
                        r_dv     <= $signed(s_tdata[39:8]);
                        r_flag   <= s_tdata[40];
                        r_rnd    <= s_tdata[56:41];
                        r_got    <= 1'b0;
                        r_winner <= '0;
                        unique case (s_tuser)
                            wpst_pkg::KIND_LOAD: r_state <= S_UPD_RD;
                            wpst_pkg::KIND_AVAIL: begin
                                if (r_avail[s_tdata[7:0]] != s_tdata[40]) begin
                                    r_state <= S_UPD_RD;
                                end else begin
                                    r_state <= S_FIN_M;
                                end
                            end
                            wpst_pkg::KIND_PICK: r_state <= S_PK_M1;
                            default: r_state <= S_FIN_M;
                        endcase
                    end
                end
                S_UPD_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_avail[r_idx] <= r_flag;
                    r_ddev  <= new_c - old_c;
                    r_dcnt  <= upd_dcnt;
                    r_p     <= 9'(r_idx) + 9'd1;
                    r_ret   <= RET_FIN;
                    r_state <= S_PW_TEST;
                end
                // walk up: a node gains the change when the path enters it from the left
                S_PW_TEST: begin
                    if (r_p[8:1] == 8'd0) begin
                        r_dtot <= r_dtot + r_ddev;
                        r_ctot <= r_ctot + 9'(r_dcnt);
                        unique case (r_ret)
                            RET_SHARE: begin
                                if (r_base > renorm_lim) begin
                                    r_state <= S_RN_M;
                                end else begin
                                    r_state <= S_FIN_M;
                                end
                            end
                            RET_REBUILD: begin
                                r_i     <= r_i + 9'd1;
                                r_state <= S_RB_NEXT;
                            end
                            default: r_state <= S_FIN_M;
                        endcase
                    end else if (!r_p[0]) begin
                        r_state <= S_PW_WR;
                    end else begin
                        r_p <= r_p >> 1;
                    end
                end
                S_PW_WR: begin
                    r_p     <= r_p >> 1;
                    r_state <= S_PW_TEST;
                end
                S_PK_M1: r_state <= S_PK_M2;
                S_PK_M2: begin
                    r_tot   <= f_clamp_tot(tot_s);
                    r_state <= S_PK_M3;
                end
                S_PK_M3: r_state <= S_PK_M4;
                S_PK_M4: begin
                    r_w <= $signed({8'b0, r_prod[55:16]});
                    r_j <= 10'd1;
                    if (r_ctot == 9'd0) begin
                        r_state <= S_FIN_M;
                    end else begin
                        r_state <= S_PK_RD;
                    end
                end
                S_PK_RD: r_state <= S_PK_MUL;
                S_PK_MUL: begin
                    r_lsum  <= tree_lsum;
                    r_devk  <= dev_rd_s;
                    r_state <= S_PK_CMP;
                end
                S_PK_CMP: begin
                    if (r_w < left_s) begin
                        r_j     <= j2;
                        r_state <= (j2 > 10'(wpst_pkg::ENTRIES)) ? S_FIN_M : S_PK_RD;
                    end else if (r_avail[pk_k] && (r_w < fit_s)) begin
                        r_got    <= 1'b1;
                        r_winner <= pk_k;
                        r_state  <= (r_ctot > 9'd1) ? S_SH_MUL : S_FIN_M;
                    end else begin
                        r_w     <= r_w - fit_s;
                        r_j     <= j2p1;
                        r_state <= (j2p1 > 10'(wpst_pkg::ENTRIES)) ? S_FIN_M : S_PK_RD;
                    end
                end
                S_SH_MUL: begin
                    r_neg   <= (wk < 48'sd0);
                    r_state <= S_SH_DIV;
                end
                S_SH_DIV: begin
                    r_shmag <= r_prod[48:16];
                    r_state <= S_SH_WAIT;
                end
                S_SH_WAIT: begin
                    if (div_rsp.done) begin
                        r_base  <= nb;
                        r_ddev  <= 40'(48'(nd_sh) - 48'(r_devk));
                        r_dcnt  <= 2'sd0;
                        r_p     <= 9'(r_winner) + 9'd1;
                        r_ret   <= RET_SHARE;
                        r_state <= S_PW_TEST;
                    end
                end
                S_RN_M: r_state <= S_RN_T;
                S_RN_T: begin
                    if (tot_s <= 48'sd0) begin
                        r_state <= S_FIN_M;
                    end else begin
                        r_t     <= tot_s[41:0];
                        r_i     <= '0;
                        r_state <= S_RN_RD;
                    end
                end
                S_RN_RD: r_state <= S_RN_MUL;
                S_RN_MUL: begin
                    r_neg   <= (wi < 48'sd0);
                    r_state <= S_RN_DIV;
                end
                S_RN_DIV: r_state <= S_RN_WAIT;
                S_RN_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_i == 9'(wpst_pkg::ENTRIES - 1)) begin
                            r_i     <= '0;
                            r_base  <= wpst_pkg::ONE_Q;
                            r_state <= S_RB_CLR;
                        end else begin
                            r_i     <= r_i + 9'd1;
                            r_state <= S_RN_RD;
                        end
                    end
                end
                S_RB_CLR: begin
                    r_i <= r_i + 9'd1;
                    if (r_i == 9'(wpst_pkg::ENTRIES - 1)) begin
                        r_i     <= '0;
                        r_dtot  <= '0;
                        r_ctot  <= '0;
                        r_state <= S_RB_NEXT;
                    end
                end
                S_RB_NEXT: begin
                    if (r_i == 9'(wpst_pkg::ENTRIES)) begin
                        r_state <= S_FIN_M;
                    end else if (r_avail[r_i[7:0]]) begin
                        r_state <= S_RB_DEV;
                    end else begin
                        r_i <= r_i + 9'd1;
                    end
                end
                S_RB_DEV: begin
                    r_ddev  <= 40'(dev_rd_s);
                    r_dcnt  <= 2'sd1;
                    r_p     <= r_i + 9'd1;
                    r_ret   <= RET_REBUILD;
                    r_state <= S_PW_TEST;
                end
                S_FIN_M: r_state <= S_FIN;
                S_FIN: begin
                    if (!r_m_valid || m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_m_valid;
    assign m_tdata     = {7'b0, r_m_cnt, r_m_tot, r_m_idx};
    assign m_tuser     = r_m_got;

    // counted total tracks the availability bits between items
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_ctot) == $countones(r_avail)))
        else $error("counted total disagrees with availability bits");

    // a pick that found a winner leaves at least one counted entry
    a_pick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[56:48] != 9'd0))
        else $error("picked result with no counted entry");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

    // divider answers only a waiting sequencer
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ((r_state == S_SH_WAIT) || (r_state == S_RN_WAIT)))
        else $error("divider result with nobody waiting");

endmodule

// ===== bench/weighted_pick_sum_tree_test.sv =====
`timescale 1ns / 100ps

module weighted_pick_sum_tree_test;
    import wpst_pkg::*;

    localparam logic [1:0] KIND_NOP   = 2'd3;     // reports totals only
    localparam logic [0:0] CFG_SHARE  = 1'b0;
    localparam logic [0:0] CFG_COUNT  = 1'b1;
    localparam int         WATCHDOG   = 200000;   // outlasts a full renormalization
    localparam int         RX_HOLD    = 600;

    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         idx;
        logic signed [31:0] dev;
        logic               flag;
        logic [15:0]        rnd;
    } pick_item_t;

    typedef struct {
        logic [7:0]  idx;
        logic        picked;
        logic [39:0] total;
        logic [8:0]  count;
    } pick_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    weighted_pick_sum_tree u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the picker state
    // ---------------------------------------------------------------
    longint     shadow_dev  [ENTRIES];
    longint     shadow_lsum [ENTRIES];     // left-subtree deviation sums, 40-bit wrap
    int         shadow_lcnt [ENTRIES];
    bit         shadow_avail[ENTRIES];
    longint     shadow_base;
    longint     shadow_devsum;
    int         shadow_counted;
    longint     shadow_share;
    int         shadow_ecount;

    pick_item_t   pending_items[$];
    pick_result_t expected_results[$];
    pick_item_t   cur_item;
    int           fail_count = 0;

    function automatic longint wrap40(longint v);
        return (v <<< 24) >>> 24;
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint weight_total();
        longint t;
        t = shadow_devsum + longint'(shadow_counted) * shadow_base;
        if (t < 0) return 0;
        if (t > 64'sh00FF_FFFF_FFFF) return 64'sh00FF_FFFF_FFFF;
        return t;
    endfunction

    function automatic int ecount_eff();
        return (shadow_ecount == 0) ? 1 : shadow_ecount;
    endfunction

    // walk ancestors; a node collects its left child's subtree
    task automatic ancestors_add(int e, longint ddev, int dcnt);
        int p;
        p = e + 1;
        while (p / 2 > 0) begin
            if ((p & 1) == 0) begin
                shadow_lsum[p/2 - 1] = wrap40(shadow_lsum[p/2 - 1] + ddev);
                shadow_lcnt[p/2 - 1] += dcnt;
            end
            p = p / 2;
        end
        shadow_devsum  = wrap40(shadow_devsum + ddev);
        shadow_counted += dcnt;
    endtask

    task automatic tree_rebuild();
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_lsum[i] = 0;
            shadow_lcnt[i] = 0;
        end
        shadow_devsum  = 0;
        shadow_counted = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_avail[i]) ancestors_add(i, shadow_dev[i], 1);
    endtask

    // num * 2^16 / den, truncated, capped at 2^40
    function automatic longint unsigned scaled_quotient(longint unsigned num,
                                                        longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q > (64'd1 << 24)) return 64'd1 << 40;
        for (int b = 0; b < FRAC_BITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return (q > (64'd1 << 40)) ? (64'd1 << 40) : q;
    endfunction

    task automatic renormalize_all();
        int     n;
        longint t, w, q;
        bit     neg;
        n = ecount_eff();
        t = shadow_devsum + longint'(n) * shadow_base;
        if (t <= 0) return;
        for (int i = 0; i < ENTRIES; i++) begin
            w   = shadow_dev[i] + shadow_base;
            neg = w < 0;
            q   = longint'(scaled_quotient(longint'(neg ? -w : w) * n, t));
            shadow_dev[i] = clamp_s32((neg ? -q : q) - longint'(ONE_Q));
        end
        shadow_base = longint'(ONE_Q);
        tree_rebuild();
    endtask

    task automatic share_winner_weight(int k);
        longint w, mag, share, dv, per, nb, nd;
        int     n;
        bit     neg;
        w     = shadow_dev[k] + shadow_base;
        neg   = w < 0;
        mag   = ((neg ? -w : w) * shadow_share) >>> 16;
        share = neg ? -mag : mag;
        n     = ecount_eff();
        dv    = (n > 1) ? longint'(n - 1) : 1;
        per   = share / dv;
        nb    = shadow_base + per;
        if (nb < 0) nb = 0;
        if (nb > 64'sd4294967295) nb = 64'sd4294967295;
        shadow_base = nb;
        nd = clamp_s32(shadow_dev[k] - share - per);
        ancestors_add(k, nd - shadow_dev[k], 0);
        shadow_dev[k] = nd;
        if (shadow_base > (longint'(n) <<< FRAC_BITS)) renormalize_all();
    endtask

    // descend the tree; returns winner or -1
    function automatic int descend_pick(logic [15:0] rnd);
        longint w, left, own;
        int     j;
        w = longint'((longint'(rnd) * weight_total()) >>> 16);
        if (shadow_counted == 0) return -1;
        j = 1;
        while (j <= ENTRIES) begin
            left = shadow_lsum[j-1] + longint'(shadow_lcnt[j-1]) * shadow_base;
            if (w < left) begin
                j = 2 * j;
            end else begin
                own = shadow_avail[j-1] ? shadow_dev[j-1] + shadow_base : 0;
                if (shadow_avail[j-1] && w < left + own) return j - 1;
                w -= left + own;
                j = 2 * j + 1;
            end
        end
        return -1;
    endfunction

    task automatic predict_outcome(pick_item_t it);
        pick_result_t res;
        int           e, winner;
        longint       oldc;
        int           oldn;
        e = it.idx;
        winner = -1;
        case (it.kind)
            KIND_LOAD: begin
                oldc = shadow_avail[e] ? shadow_dev[e] : 0;
                oldn = shadow_avail[e] ? 1 : 0;
                shadow_dev[e]   = longint'(it.dev);
                shadow_avail[e] = it.flag;
                ancestors_add(e, (it.flag ? longint'(it.dev) : 0) - oldc,
                              (it.flag ? 1 : 0) - oldn);
            end
            KIND_AVAIL: begin
                if (shadow_avail[e] != it.flag) begin
                    shadow_avail[e] = it.flag;
                    if (it.flag) ancestors_add(e, shadow_dev[e], 1);
                    else         ancestors_add(e, -shadow_dev[e], -1);
                end
            end
            KIND_PICK: begin
                winner = descend_pick(it.rnd);
                if (winner >= 0 && shadow_counted > 1) share_winner_weight(winner);
            end
            default: ;
        endcase
        res.idx    = (winner >= 0) ? winner[7:0] : 8'd0;
        res.picked = winner >= 0;
        res.total  = weight_total();
        res.count  = shadow_counted[8:0];
        expected_results.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Driver: feeds items from pending_items
    // ---------------------------------------------------------------
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;     // watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_outcome(cur_item);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, cur_item.rnd, cur_item.flag, cur_item.dev,
                                 cur_item.idx};
                    s_tuser  <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result, random backpressure, one long hold on request
    // ---------------------------------------------------------------
    bit rx_hold_req = 1'b0;
    bit rx_hold_done = 1'b0;
    int rx_hold_left = 0;

    always @(posedge i_clk) begin
        pick_result_t exp_r;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[7:0] !== exp_r.idx) begin
                        $error("picked_index expected %0d got %0d", exp_r.idx, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_r.picked) begin
                        $error("picked expected %0d got %0d", exp_r.picked, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[47:8] !== exp_r.total) begin
                        $error("total_weight expected %0d got %0d", exp_r.total,
                               m_tdata[47:8]);
                        fail_count++;
                    end
                    if (m_tdata[56:48] !== exp_r.count) begin
                        $error("counted_entries expected %0d got %0d", exp_r.count,
                               m_tdata[56:48]);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold_left = RX_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= rx_idle_pct;
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic pick_item_t make_item(logic [1:0] kind, int e, logic [31:0] dev,
                                             logic flag, logic [15:0] rnd);
        pick_item_t it;
        it.kind = kind;
        it.idx  = e[7:0];
        it.dev  = dev;
        it.flag = flag;
        it.rnd  = rnd;
        return it;
    endfunction

    // small deviations keep weights near the base; some full-range values
    function automatic pick_item_t random_item(int pick_pct);
        pick_item_t it;
        int         sel;
        sel = $urandom_range(99);
        if (sel < pick_pct)                         it.kind = KIND_PICK;
        else if (sel < pick_pct + (100-pick_pct)/2) it.kind = KIND_LOAD;
        else if (sel < 95)                          it.kind = KIND_AVAIL;
        else                                        it.kind = KIND_NOP;
        it.idx  = $urandom_range(255);
        it.dev  = ($urandom_range(9) == 0) ? $urandom()
                                           : 32'($urandom_range(196608) - 65536);
        it.flag = $urandom_range(3) != 0;
        it.rnd  = $urandom();
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [0:0] reg_idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (reg_idx == CFG_SHARE) shadow_share  = value;
        else                      shadow_ecount = value[8:0];
    endtask

    task automatic run_phase(int n_items, int pick_pct);
        for (int i = 0; i < n_items; i++) pending_items.push_back(random_item(pick_pct));
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_dev[i]   = 0;
            shadow_avail[i] = 1'b0;
        end
        shadow_base   = longint'(ONE_Q);
        shadow_share  = 0;
        shadow_ecount = 256;
        tree_rebuild();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pick, lone entry, extremes, falling off the tree
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h0000));
        pending_items.push_back(make_item(KIND_NOP, 255, 32'hFFFF_FFFF, 1, 16'hFFFF));
        pending_items.push_back(make_item(KIND_LOAD, 0, 0, 1, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_item(KIND_AVAIL, 0, 0, 1, 0));      // unchanged
        pending_items.push_back(make_item(KIND_LOAD, 255, 32'h7FFF_FFFF, 1, 0));
        pending_items.push_back(make_item(KIND_LOAD, 128, 32'h8000_0000, 1, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h0000));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_item(KIND_AVAIL, 128, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h8000));
        pending_items.push_back(make_item(KIND_AVAIL, 128, 0, 1, 0));
        pending_items.push_back(make_item(KIND_LOAD, 255, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h4000));
        pending_items.push_back(make_item(KIND_LOAD, 7, -32'sd196608, 1, 0));
        pending_items.push_back(make_item(KIND_LOAD, 3, 32'h1234_5678, 0, 0));
        pending_items.push_back(make_item(KIND_AVAIL, 3, 0, 1, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'hC000));
        pending_items.push_back(make_item(KIND_AVAIL, 128, 0, 0, 0));
        pending_items.push_back(make_item(KIND_LOAD, 3, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h7FFF));
        pending_items.push_back(make_item(KIND_LOAD, 0, 32'h0001_0000, 1, 0));
        pending_items.push_back(make_item(KIND_PICK, 0, 0, 0, 16'h0001));
        wait_drained();

        // receiver idles more than sender; one long receiver hold
        cfg_write(CFG_SHARE, 16'h8000);
        tx_idle_pct = 13;
        rx_idle_pct = 62;
        rx_hold_req = 1'b1;
        run_phase(380, 35);

        // sender idles more; full share ratio
        cfg_write(CFG_SHARE, 16'hFFFF);
        tx_idle_pct = 62;
        rx_idle_pct = 13;
        run_phase(370, 35);

        // tiny entry counts: renormalization on nearly every pick, keep short
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cfg_write(CFG_COUNT, 16'd1);
        run_phase(20, 25);
        cfg_write(CFG_COUNT, 16'd0);
        run_phase(20, 25);
        cfg_write(CFG_COUNT, 16'd2);
        cfg_write(CFG_SHARE, 16'd0);
        run_phase(20, 40);
        cfg_write(CFG_SHARE, 16'h1000);
        run_phase(20, 25);

        // back to full size, random ratio, no idling
        cfg_write(CFG_COUNT, 16'd256);
        cfg_write(CFG_SHARE, 16'($urandom()));
        run_phase(320, 35);

        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
